### hdl/vpcn_pkg.sv
package vpcn_pkg;

    localparam int COORD_W = 32;
    localparam int RAD_W   = COORD_W - 1;

    typedef logic signed [COORD_W-1:0] t_coord;

    localparam t_coord C_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam t_coord C_MIN = {1'b1, {(COORD_W-1){1'b0}}};

    // command kinds
    localparam logic [3:0] K_MOVE   = 4'd0;
    localparam logic [3:0] K_LINE   = 4'd1;
    localparam logic [3:0] K_HLINE  = 4'd2;
    localparam logic [3:0] K_VLINE  = 4'd3;
    localparam logic [3:0] K_CUBIC  = 4'd4;
    localparam logic [3:0] K_SCUBIC = 4'd5;
    localparam logic [3:0] K_QUAD   = 4'd6;
    localparam logic [3:0] K_SQUAD  = 4'd7;
    localparam logic [3:0] K_ARC    = 4'd8;
    localparam logic [3:0] K_CLOSE  = 4'd9;
    localparam logic [3:0] K_REPEAT = 4'd10;
    localparam logic [3:0] K_END    = 4'd11;

    // result status
    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_ERR = 2'd1;
    localparam logic [1:0] ST_END = 2'd2;

    // register indexes
    localparam logic CFG_POINTS_MODE    = 1'b0;
    localparam logic CFG_IMPLICIT_CLOSE = 1'b1;

    typedef struct packed {
        logic [3:0] kind;
        logic       is_absolute;
        t_coord     arg0;
        t_coord     arg1;
        t_coord     arg2;
        t_coord     arg3;
        t_coord     arg4;
        t_coord     arg5;
        logic       large_arc_flag;
        logic       sweep_flag;
    } t_in;

    typedef struct packed {
        logic [1:0]       status;
        logic [3:0]       command;
        t_coord           end_x;
        t_coord           end_y;
        t_coord           ctrl1_x;
        t_coord           ctrl1_y;
        t_coord           ctrl2_x;
        t_coord           ctrl2_y;
        logic [RAD_W-1:0] radius_x;
        logic [RAD_W-1:0] radius_y;
        t_coord           rotation;
        logic [1:0]       arc_flags;
    } t_out;

    typedef struct packed {
        t_coord     cur_x;
        t_coord     cur_y;
        t_coord     start_x;
        t_coord     start_y;
        t_coord     cp1_x;
        t_coord     cp1_y;
        t_coord     cp2_x;
        t_coord     cp2_y;
        logic [3:0] current_cmd;
        logic [3:0] previous_cmd;
        logic       first_pending;
        logic       close_emitted;
        logic       absolute_mode;
    } t_state;

    function automatic t_coord sat_add(input t_coord a, input t_coord b);
        logic [COORD_W:0] s;
        s = {a[COORD_W-1], a} + {b[COORD_W-1], b};
        if (s[COORD_W] != s[COORD_W-1]) begin
            sat_add = s[COORD_W] ? C_MIN : C_MAX;
        end else begin
            sat_add = s[COORD_W-1:0];
        end
    endfunction

    function automatic t_coord sat_sub(input t_coord a, input t_coord b);
        logic [COORD_W:0] s;
        s = {a[COORD_W-1], a} - {b[COORD_W-1], b};
        if (s[COORD_W] != s[COORD_W-1]) begin
            sat_sub = s[COORD_W] ? C_MIN : C_MAX;
        end else begin
            sat_sub = s[COORD_W-1:0];
        end
    endfunction

    // |a|, with the most negative value pinned to the largest magnitude
    function automatic logic [RAD_W-1:0] mag(input t_coord a);
        t_coord neg;
        neg = -a;
        if (a == C_MIN) begin
            mag = C_MAX[RAD_W-1:0];
        end else if (a[COORD_W-1]) begin
            mag = neg[RAD_W-1:0];
        end else begin
            mag = a[RAD_W-1:0];
        end
    endfunction

endpackage

### hdl/vpcn_in_reg.sv
module vpcn_in_reg (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  vpcn_pkg::t_in i_in_data,
    output logic          o_valid,
    output vpcn_pkg::t_in o_data,
    input  logic          i_take
);

    logic          r_valid;
    logic          n_valid;
    vpcn_pkg::t_in r_data;
    logic          load;

    assign o_in_stall = r_valid && !i_take;
    assign load       = i_in_valid && !o_in_stall;
    assign n_valid    = load ? 1'b1 : (i_take ? 1'b0 : r_valid);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_data <= i_in_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

### hdl/vpcn_resolve.sv
module vpcn_resolve (
    input  vpcn_pkg::t_in    i_item,
    input  vpcn_pkg::t_state i_state,
    input  logic             i_points_mode,
    input  logic             i_implicit_close,
    output vpcn_pkg::t_state o_state,
    output vpcn_pkg::t_out   o_result
);

    logic [3:0]       cmd;
    logic             absn;
    logic             err;
    vpcn_pkg::t_coord bx, by;
    vpcn_pkg::t_coord sx0, sy0, sy1, sx2, sx3, sy3, sy4, sx4, sy5;
    vpcn_pkg::t_coord refl_px, refl_py, refl_x, refl_y;
    vpcn_pkg::t_coord nx, ny, c1x, c1y, c2x, c2y;
    logic [vpcn_pkg::RAD_W-1:0] rad_x, rad_y;

    // command resolution
    always_comb begin
        err  = 1'b0;
        cmd  = i_item.kind;
        absn = i_item.is_absolute;
        if (i_points_mode) begin
            cmd  = i_state.first_pending ? vpcn_pkg::K_MOVE : vpcn_pkg::K_LINE;
            absn = 1'b1;
        end else if (i_item.kind == vpcn_pkg::K_REPEAT) begin
            err  = i_state.first_pending || (i_state.current_cmd == vpcn_pkg::K_CLOSE);
            cmd  = (i_state.current_cmd == vpcn_pkg::K_MOVE) ? vpcn_pkg::K_LINE
                                                              : i_state.current_cmd;
            absn = i_state.absolute_mode;
        end else if (i_item.kind inside {[4'd12:4'd15]}) begin
            err = 1'b1;
        end
    end

    assign bx = absn ? '0 : i_state.cur_x;
    assign by = absn ? '0 : i_state.cur_y;

    assign sx0 = vpcn_pkg::sat_add(i_item.arg0, bx);
    assign sy0 = vpcn_pkg::sat_add(i_item.arg0, by);
    assign sy1 = vpcn_pkg::sat_add(i_item.arg1, by);
    assign sx2 = vpcn_pkg::sat_add(i_item.arg2, bx);
    assign sx3 = vpcn_pkg::sat_add(i_item.arg3, bx);
    assign sy3 = vpcn_pkg::sat_add(i_item.arg3, by);
    assign sy4 = vpcn_pkg::sat_add(i_item.arg4, by);
    assign sx4 = vpcn_pkg::sat_add(i_item.arg4, bx);
    assign sy5 = vpcn_pkg::sat_add(i_item.arg5, by);

    // smooth cubic reflects cp2, smooth quad reflects cp1
    assign refl_px = (cmd == vpcn_pkg::K_SCUBIC) ? i_state.cp2_x : i_state.cp1_x;
    assign refl_py = (cmd == vpcn_pkg::K_SCUBIC) ? i_state.cp2_y : i_state.cp1_y;
    assign refl_x  = vpcn_pkg::sat_add(i_state.cur_x,
                                       vpcn_pkg::sat_sub(i_state.cur_x, refl_px));
    assign refl_y  = vpcn_pkg::sat_add(i_state.cur_y,
                                       vpcn_pkg::sat_sub(i_state.cur_y, refl_py));

    assign rad_x = vpcn_pkg::mag(i_item.arg0);
    assign rad_y = vpcn_pkg::mag(i_item.arg1);

    always_comb begin
        nx  = i_state.cur_x;
        ny  = i_state.cur_y;
        c1x = i_state.cp1_x;
        c1y = i_state.cp1_y;
        c2x = i_state.cp2_x;
        c2y = i_state.cp2_y;
        case (cmd)
            vpcn_pkg::K_MOVE, vpcn_pkg::K_LINE: begin
                nx = sx0;
                ny = sy1;
            end
            vpcn_pkg::K_HLINE: nx = sx0;
            vpcn_pkg::K_VLINE: ny = sy0;
            vpcn_pkg::K_CUBIC: begin
                c1x = sx0;
                c1y = sy1;
                c2x = sx2;
                c2y = sy3;
                nx  = sx4;
                ny  = sy5;
            end
            vpcn_pkg::K_SCUBIC: begin
                if (i_state.previous_cmd == vpcn_pkg::K_CUBIC ||
                    i_state.previous_cmd == vpcn_pkg::K_SCUBIC) begin
                    c1x = refl_x;
                    c1y = refl_y;
                end else begin
                    c1x = i_state.cur_x;
                    c1y = i_state.cur_y;
                end
                c2x = sx0;
                c2y = sy1;
                nx  = sx2;
                ny  = sy3;
            end
            vpcn_pkg::K_QUAD: begin
                c1x = sx0;
                c1y = sy1;
                nx  = sx2;
                ny  = sy3;
            end
            vpcn_pkg::K_SQUAD: begin
                if (i_state.previous_cmd == vpcn_pkg::K_QUAD ||
                    i_state.previous_cmd == vpcn_pkg::K_SQUAD) begin
                    c1x = refl_x;
                    c1y = refl_y;
                end else begin
                    c1x = i_state.cur_x;
                    c1y = i_state.cur_y;
                end
                nx = sx0;
                ny = sy1;
            end
            vpcn_pkg::K_ARC: begin
                nx = sx3;
                ny = sy4;
            end
            default: begin
                nx = i_state.start_x;
                ny = i_state.start_y;
            end
        endcase
    end

    always_comb begin
        o_state  = i_state;
        o_result = '0;
        if (i_item.kind == vpcn_pkg::K_END) begin
            if (i_implicit_close && !i_state.close_emitted) begin
                // one closing segment, previous_cmd left as is
                o_state.close_emitted = 1'b1;
                o_state.current_cmd   = vpcn_pkg::K_CLOSE;
                o_state.cur_x         = i_state.start_x;
                o_state.cur_y         = i_state.start_y;
                o_result.command      = vpcn_pkg::K_CLOSE;
                o_result.end_x        = i_state.start_x;
                o_result.end_y        = i_state.start_y;
            end else begin
                o_result.status = vpcn_pkg::ST_END;
            end
        end else if (err || (cmd == vpcn_pkg::K_ARC &&
                             (rad_x == '0 || rad_y == '0))) begin
            o_result.status = vpcn_pkg::ST_ERR;
        end else begin
            o_state.cur_x = nx;
            o_state.cur_y = ny;
            o_state.cp1_x = c1x;
            o_state.cp1_y = c1y;
            o_state.cp2_x = c2x;
            o_state.cp2_y = c2y;
            if (cmd == vpcn_pkg::K_MOVE) begin
                o_state.start_x = nx;
                o_state.start_y = ny;
            end
            if (!i_points_mode) begin
                o_state.absolute_mode = absn;
            end
            o_state.first_pending = 1'b0;
            o_state.previous_cmd  = cmd;
            o_state.current_cmd   = cmd;

            o_result.command = cmd;
            o_result.end_x   = nx;
            o_result.end_y   = ny;
            if (cmd inside {[vpcn_pkg::K_CUBIC:vpcn_pkg::K_SQUAD]}) begin
                o_result.ctrl1_x = c1x;
                o_result.ctrl1_y = c1y;
            end
            if (cmd == vpcn_pkg::K_CUBIC || cmd == vpcn_pkg::K_SCUBIC) begin
                o_result.ctrl2_x = c2x;
                o_result.ctrl2_y = c2y;
            end
            if (cmd == vpcn_pkg::K_ARC) begin
                o_result.radius_x  = rad_x;
                o_result.radius_y  = rad_y;
                o_result.rotation  = i_item.arg2;
                o_result.arc_flags = {i_item.sweep_flag, i_item.large_arc_flag};
            end
        end
    end

endmodule

### hdl/vector_path_command_normalizer.sv
// Channel   Direction  Handshake                  Payload
// config    in         i_cfg_we (write, no wait)  i_cfg_index, i_cfg_data
// command   in         i_in_valid / o_in_stall    i_in_data  (vpcn_pkg::t_in)
// result    out        o_out_valid / i_out_stall  o_out_data (vpcn_pkg::t_out)
//
// One command per cycle while the result side does not stall; a command
// passes the input register, then the resolve logic feeding the result register and the path state.
// The path state updates in the same edge that loads the result, so a
// command sees everything the one before it left.
// Synchronous active-low reset clears the path state, config and valids.
// A stalled result holds; the input register keeps taking one more command.

module vector_path_command_normalizer (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  logic           i_cfg_index,
    input  logic           i_cfg_data,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  vpcn_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output vpcn_pkg::t_out o_out_data
);

    // path state after reset: no command yet, history reads as closepath
    localparam vpcn_pkg::t_state STATE_INIT = '{
        current_cmd:   vpcn_pkg::K_CLOSE,
        previous_cmd:  vpcn_pkg::K_CLOSE,
        first_pending: 1'b1,
        default:       '0
    };

    logic             r_points_mode;
    logic             r_implicit_close;

    logic             stg_valid;
    vpcn_pkg::t_in    stg_data;
    logic             advance;

    vpcn_pkg::t_state r_state;
    vpcn_pkg::t_state n_state;
    vpcn_pkg::t_out   n_out;
    vpcn_pkg::t_out   r_out;
    logic             r_out_valid;

    // config port: plain writes; the user must issue them only while idle, the block does not enforce it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_points_mode    <= 1'b0;
            r_implicit_close <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                vpcn_pkg::CFG_POINTS_MODE:    r_points_mode    <= i_cfg_data;
                vpcn_pkg::CFG_IMPLICIT_CLOSE: r_implicit_close <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // staged command moves on when the result slot is free or draining
    assign advance = stg_valid && (!r_out_valid || !i_out_stall);

    vpcn_in_reg u_in_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_valid    (stg_valid),
        .o_data     (stg_data),
        .i_take     (advance)
    );

    vpcn_resolve u_resolve (
        .i_item           (stg_data),
        .i_state          (r_state),
        .i_points_mode    (r_points_mode),
        .i_implicit_close (r_implicit_close),
        .o_state          (n_state),
        .o_result         (n_out)
    );

    // path state: current point, subpath start, control points, history
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= STATE_INIT;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

### bench/vpcn_checker.sv
`timescale 1ns / 1ps

module vpcn_checker (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  logic           i_cfg_index,
    input  logic           i_cfg_data,
    input  logic           i_in_valid,
    input  logic           i_in_stall,
    input  vpcn_pkg::t_in  i_in_data,
    input  logic           i_out_valid,
    input  logic           i_out_stall,
    input  vpcn_pkg::t_out i_out_data,
    output int             o_fails,
    output int             o_pending,
    output int             o_checked
);

    // path state as the block should hold it
    vpcn_pkg::t_coord pen_x, pen_y;       // current point
    vpcn_pkg::t_coord sub_x, sub_y;       // subpath start
    vpcn_pkg::t_coord ctl1_x, ctl1_y, ctl2_x, ctl2_y;
    logic [3:0]       last_cmd, prior_cmd;
    logic             no_cmd_yet, close_done, repeat_abs;
    logic             points_on, close_on_end;

    vpcn_pkg::t_out   expected_q[$];

    function automatic vpcn_pkg::t_coord clamp_coord(input longint v);
        if (v > longint'(vpcn_pkg::C_MAX)) return vpcn_pkg::C_MAX;
        if (v < longint'(vpcn_pkg::C_MIN)) return vpcn_pkg::C_MIN;
        return vpcn_pkg::t_coord'(v);
    endfunction

    function automatic vpcn_pkg::t_coord add_coord(input vpcn_pkg::t_coord a,
                                                   input vpcn_pkg::t_coord b);
        return clamp_coord(longint'(a) + longint'(b));
    endfunction

    // mirror control point c about point p: p + (p - c), both steps clamped
    function automatic vpcn_pkg::t_coord reflect(input vpcn_pkg::t_coord p,
                                                 input vpcn_pkg::t_coord c);
        return add_coord(p, clamp_coord(longint'(p) - longint'(c)));
    endfunction

    function automatic logic [vpcn_pkg::RAD_W-1:0] radius_of(input vpcn_pkg::t_coord a);
        longint m;
        m = (a < 0) ? -longint'(a) : longint'(a);
        if (m > longint'(vpcn_pkg::C_MAX)) m = longint'(vpcn_pkg::C_MAX);
        return m[vpcn_pkg::RAD_W-1:0];
    endfunction

    task automatic resolve_command(input vpcn_pkg::t_in c, output vpcn_pkg::t_out r);
        logic [3:0]                 cmd;
        logic                       absn, bad;
        vpcn_pkg::t_coord           bx, by, nx, ny, c1x, c1y, c2x, c2y;
        logic [vpcn_pkg::RAD_W-1:0] rx, ry;
        r   = '0;
        bad = 1'b0;
        rx  = '0;
        ry  = '0;
        if (c.kind == vpcn_pkg::K_END) begin
            if (close_on_end && !close_done) begin
                // one closing segment; prior_cmd stays as it was
                close_done = 1'b1;
                last_cmd   = vpcn_pkg::K_CLOSE;
                pen_x      = sub_x;
                pen_y      = sub_y;
                r.command  = vpcn_pkg::K_CLOSE;
                r.end_x    = pen_x;
                r.end_y    = pen_y;
            end else begin
                r.status = vpcn_pkg::ST_END;
            end
        end else begin
            cmd  = c.kind;
            absn = c.is_absolute;
            if (points_on) begin
                cmd  = no_cmd_yet ? vpcn_pkg::K_MOVE : vpcn_pkg::K_LINE;
                absn = 1'b1;
            end else if (c.kind == vpcn_pkg::K_REPEAT) begin
                bad  = no_cmd_yet || last_cmd == vpcn_pkg::K_CLOSE;
                cmd  = (last_cmd == vpcn_pkg::K_MOVE) ? vpcn_pkg::K_LINE : last_cmd;
                absn = repeat_abs;
            end else if (c.kind > vpcn_pkg::K_END) begin
                bad = 1'b1;
            end
            bx  = absn ? '0 : pen_x;
            by  = absn ? '0 : pen_y;
            nx  = pen_x;
            ny  = pen_y;
            c1x = ctl1_x;
            c1y = ctl1_y;
            c2x = ctl2_x;
            c2y = ctl2_y;
            case (cmd)
                vpcn_pkg::K_MOVE, vpcn_pkg::K_LINE: begin
                    nx = add_coord(c.arg0, bx);
                    ny = add_coord(c.arg1, by);
                end
                vpcn_pkg::K_HLINE: nx = add_coord(c.arg0, bx);
                vpcn_pkg::K_VLINE: ny = add_coord(c.arg0, by);
                vpcn_pkg::K_CUBIC: begin
                    c1x = add_coord(c.arg0, bx);
                    c1y = add_coord(c.arg1, by);
                    c2x = add_coord(c.arg2, bx);
                    c2y = add_coord(c.arg3, by);
                    nx  = add_coord(c.arg4, bx);
                    ny  = add_coord(c.arg5, by);
                end
                vpcn_pkg::K_SCUBIC: begin
                    if (prior_cmd == vpcn_pkg::K_CUBIC ||
                        prior_cmd == vpcn_pkg::K_SCUBIC) begin
                        c1x = reflect(pen_x, ctl2_x);
                        c1y = reflect(pen_y, ctl2_y);
                    end else begin
                        c1x = pen_x;
                        c1y = pen_y;
                    end
                    c2x = add_coord(c.arg0, bx);
                    c2y = add_coord(c.arg1, by);
                    nx  = add_coord(c.arg2, bx);
                    ny  = add_coord(c.arg3, by);
                end
                vpcn_pkg::K_QUAD: begin
                    c1x = add_coord(c.arg0, bx);
                    c1y = add_coord(c.arg1, by);
                    nx  = add_coord(c.arg2, bx);
                    ny  = add_coord(c.arg3, by);
                end
                vpcn_pkg::K_SQUAD: begin
                    if (prior_cmd == vpcn_pkg::K_QUAD ||
                        prior_cmd == vpcn_pkg::K_SQUAD) begin
                        c1x = reflect(pen_x, ctl1_x);
                        c1y = reflect(pen_y, ctl1_y);
                    end else begin
                        c1x = pen_x;
                        c1y = pen_y;
                    end
                    nx = add_coord(c.arg0, bx);
                    ny = add_coord(c.arg1, by);
                end
                vpcn_pkg::K_ARC: begin
                    rx = radius_of(c.arg0);
                    ry = radius_of(c.arg1);
                    if (rx == '0 || ry == '0) bad = 1'b1;
                    nx = add_coord(c.arg3, bx);
                    ny = add_coord(c.arg4, by);
                end
                default: begin
                    nx = sub_x;
                    ny = sub_y;
                end
            endcase

            if (bad) begin
                r.status = vpcn_pkg::ST_ERR;
            end else begin
                pen_x  = nx;
                pen_y  = ny;
                ctl1_x = c1x;
                ctl1_y = c1y;
                ctl2_x = c2x;
                ctl2_y = c2y;
                if (cmd == vpcn_pkg::K_MOVE) begin
                    sub_x = nx;
                    sub_y = ny;
                end
                if (!points_on) repeat_abs = absn;
                no_cmd_yet = 1'b0;
                prior_cmd  = cmd;
                last_cmd   = cmd;
                r.command  = cmd;
                r.end_x    = nx;
                r.end_y    = ny;
                if (cmd >= vpcn_pkg::K_CUBIC && cmd <= vpcn_pkg::K_SQUAD) begin
                    r.ctrl1_x = c1x;
                    r.ctrl1_y = c1y;
                end
                if (cmd == vpcn_pkg::K_CUBIC || cmd == vpcn_pkg::K_SCUBIC) begin
                    r.ctrl2_x = c2x;
                    r.ctrl2_y = c2y;
                end
                if (cmd == vpcn_pkg::K_ARC) begin
                    r.radius_x  = rx;
                    r.radius_y  = ry;
                    r.rotation  = c.arg2;
                    r.arc_flags = {c.sweep_flag, c.large_arc_flag};
                end
            end
        end
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %h, got %h", name, want, got);
            o_fails++;
        end
    endtask

    always @(posedge i_clk) begin : watch
        vpcn_pkg::t_out want;
        vpcn_pkg::t_out got;
        if (!i_rst_n) begin
            pen_x        = '0;
            pen_y        = '0;
            sub_x        = '0;
            sub_y        = '0;
            ctl1_x       = '0;
            ctl1_y       = '0;
            ctl2_x       = '0;
            ctl2_y       = '0;
            last_cmd     = vpcn_pkg::K_CLOSE;
            prior_cmd    = vpcn_pkg::K_CLOSE;
            no_cmd_yet   = 1'b1;
            close_done   = 1'b0;
            repeat_abs   = 1'b0;
            points_on    = 1'b0;
            close_on_end = 1'b0;
            expected_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    vpcn_pkg::CFG_POINTS_MODE:    points_on    = i_cfg_data;
                    vpcn_pkg::CFG_IMPLICIT_CLOSE: close_on_end = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                got = i_out_data;
                if (expected_q.size() == 0) begin
                    $error("result with no command waiting: status %0d command %0d",
                           got.status, got.command);
                    o_fails++;
                end else begin
                    want = expected_q.pop_front();
                    compare_field("status",    32'(want.status),    32'(got.status));
                    compare_field("command",   32'(want.command),   32'(got.command));
                    compare_field("end_x",     want.end_x,          got.end_x);
                    compare_field("end_y",     want.end_y,          got.end_y);
                    compare_field("ctrl1_x",   want.ctrl1_x,        got.ctrl1_x);
                    compare_field("ctrl1_y",   want.ctrl1_y,        got.ctrl1_y);
                    compare_field("ctrl2_x",   want.ctrl2_x,        got.ctrl2_x);
                    compare_field("ctrl2_y",   want.ctrl2_y,        got.ctrl2_y);
                    compare_field("radius_x",  32'(want.radius_x),  32'(got.radius_x));
                    compare_field("radius_y",  32'(want.radius_y),  32'(got.radius_y));
                    compare_field("rotation",  want.rotation,       got.rotation);
                    compare_field("arc_flags", 32'(want.arc_flags), 32'(got.arc_flags));
                    o_checked++;
                end
            end
            if (i_in_valid && !i_in_stall) begin
                resolve_command(i_in_data, want);
                expected_q.push_back(want);
            end
        end
        o_pending = expected_q.size();
    end

endmodule

### bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    // Hard stop for a run that hangs.
    localparam int CYCLE_LIMIT = 400000;
    // Random commands per register setting, four settings in all.
    localparam int PHASE_ITEMS = 325;

    logic           clk;
    logic           rst_n;
    logic           cfg_we;
    logic           cfg_index;
    logic           cfg_data;
    logic           in_valid;
    logic           in_stall;
    vpcn_pkg::t_in  in_data;
    logic           out_valid;
    logic           out_stall = 1'b0;
    vpcn_pkg::t_out out_data;

    int          fails;
    int          pending;
    int          checked;
    int          idle_pct    = 32;   // shared by sender gaps and result stalls
    int          n_sent      = 0;
    int          n_settings  = 0;
    int unsigned cycle_count = 0;

    vector_path_command_normalizer i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    // Watches both channels and the register port, predicts and compares.
    vpcn_checker path_check (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .i_in_stall  (in_stall),
        .i_in_data   (in_data),
        .i_out_valid (out_valid),
        .i_out_stall (out_stall),
        .i_out_data  (out_data),
        .o_fails     (fails),
        .o_pending   (pending),
        .o_checked   (checked)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
    end

    // Timeout: a hung handshake or lost result ends up here.
    initial begin
        while (cycle_count < CYCLE_LIMIT) @(posedge clk);
        $display("TB_ERROR");
        $finish;
    end

    // Result side: stall at random, one decision per falling edge.
    always @(negedge clk) begin
        out_stall <= ($urandom_range(99) < idle_pct);
    end

    // Coordinates: mostly within +/-1000.0 so relative paths wander without
    // pinning, with the rails, zero and full-range words mixed in.
    function automatic vpcn_pkg::t_coord rand_coord();
        case ($urandom_range(15))
            0:       return vpcn_pkg::C_MAX;
            1:       return vpcn_pkg::C_MIN;
            2:       return '0;
            3, 4, 5: return vpcn_pkg::t_coord'($urandom);
            default: return vpcn_pkg::t_coord'(int'($urandom_range(131072000)) - 65536000);
        endcase
    endfunction

    function automatic vpcn_pkg::t_in make_cmd(input logic [3:0] kind, input logic absolute);
        vpcn_pkg::t_in c;
        c.kind           = kind;
        c.is_absolute    = absolute;
        c.arg0           = rand_coord();
        c.arg1           = rand_coord();
        c.arg2           = rand_coord();
        c.arg3           = rand_coord();
        c.arg4           = rand_coord();
        c.arg5           = rand_coord();
        c.large_arc_flag = 1'($urandom_range(1));
        c.sweep_flag     = 1'($urandom_range(1));
        return c;
    endfunction

    // Called at a falling edge, returns at the falling edge after the transfer.
    // Valid is left high on return; the next send or drain decides what it does,
    // so it only ever gets one assignment per edge.
    task automatic send_cmd(input vpcn_pkg::t_in c);
        bit taken;
        while ($urandom_range(99) < idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= c;
        taken = 1'b0;
        while (!taken) begin
            @(posedge clk);
            taken = !in_stall;
        end
        @(negedge clk);
        n_sent++;
    endtask

    task automatic send_at(input logic [3:0] kind, input logic absolute,
                           input vpcn_pkg::t_coord x, input vpcn_pkg::t_coord y);
        vpcn_pkg::t_in c;
        c      = make_cmd(kind, absolute);
        c.arg0 = x;
        c.arg1 = y;
        send_cmd(c);
    endtask

    // Hold the sender off until every expected result has been seen, then let
    // the two-stage pipe settle.
    task automatic drain();
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
        @(negedge clk);
    endtask

    task automatic set_mode(input logic pts, input logic close_end);
        write_reg(vpcn_pkg::CFG_POINTS_MODE, pts);
        write_reg(vpcn_pkg::CFG_IMPLICIT_CLOSE, close_end);
        n_settings++;
    endtask

    // Well-formed path: moveto, a run of drawing commands and repeats,
    // sometimes a closepath, now and then an end marker.
    task automatic send_path();
        int         len;
        logic [3:0] k;
        len = int'($urandom_range(12, 1));
        send_cmd(make_cmd(vpcn_pkg::K_MOVE, 1'($urandom_range(1))));
        repeat (len) begin
            k = 4'($urandom_range(8));
            send_cmd(make_cmd((k == 4'd0) ? vpcn_pkg::K_REPEAT : k, 1'($urandom_range(1))));
        end
        if ($urandom_range(1) != 0) begin
            send_cmd(make_cmd(vpcn_pkg::K_CLOSE, 1'($urandom_range(1))));
        end
        if ($urandom_range(7) == 0) begin
            send_cmd(make_cmd(vpcn_pkg::K_END, 1'($urandom_range(1))));
        end
    endtask

    // Anything at all, unknown kinds included.
    task automatic send_noise();
        logic [3:0] k;
        k = 4'($urandom_range(15));
        send_cmd(make_cmd(k, 1'($urandom_range(1))));
    endtask

    initial begin
        int mark;
        cfg_we    = 1'b0;
        cfg_index = 1'b0;
        cfg_data  = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        rst_n     = 1'b0;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;

        // ---- directed part ----
        set_mode(1'b0, 1'b0);
        send_at(vpcn_pkg::K_REPEAT, 1'b1, '0, '0);  // repeat with nothing before it
        send_at(4'd12, 1'b0, '0, '0);               // unknown kinds, both ends
        send_at(4'd15, 1'b1, vpcn_pkg::C_MAX, vpcn_pkg::C_MIN);
        send_at(vpcn_pkg::K_END, 1'b0, '0, '0);     // end with implicit close off

        // Points mode while nothing has been drawn yet: moveto, then lineto.
        drain();
        set_mode(1'b1, 1'b0);
        send_at(vpcn_pkg::K_ARC, 1'b0, vpcn_pkg::C_MAX, vpcn_pkg::C_MIN);
        send_at(vpcn_pkg::K_REPEAT, 1'b0, vpcn_pkg::C_MIN, vpcn_pkg::C_MAX);

        drain();
        set_mode(1'b0, 1'b0);
        send_at(vpcn_pkg::K_MOVE, 1'b0, vpcn_pkg::t_coord'(100 * 65536),
                vpcn_pkg::t_coord'(-200 * 65536));
        send_at(vpcn_pkg::K_LINE, 1'b1, vpcn_pkg::C_MAX, vpcn_pkg::C_MAX);
        // pins at the rail
        send_at(vpcn_pkg::K_LINE, 1'b0, vpcn_pkg::t_coord'(1), vpcn_pkg::t_coord'(1));
        send_at(vpcn_pkg::K_HLINE, 1'b0, vpcn_pkg::C_MIN, '0);
        send_at(vpcn_pkg::K_VLINE, 1'b1, vpcn_pkg::t_coord'(-5 * 65536), '0);
        send_at(vpcn_pkg::K_CUBIC, 1'b1, rand_coord(), rand_coord());
        send_at(vpcn_pkg::K_SCUBIC, 1'b0, rand_coord(), rand_coord()); // reflects cubic ctrl2
        send_at(vpcn_pkg::K_SQUAD, 1'b1, rand_coord(), rand_coord());  // no quad before
        send_at(vpcn_pkg::K_QUAD, 1'b0, rand_coord(), rand_coord());
        send_at(vpcn_pkg::K_SQUAD, 1'b0, rand_coord(), rand_coord());  // reflects quad ctrl
        // radius magnitude pins
        send_at(vpcn_pkg::K_ARC, 1'b1, vpcn_pkg::C_MIN, vpcn_pkg::t_coord'(-5));
        // zero radius
        send_at(vpcn_pkg::K_ARC, 1'b1, '0, vpcn_pkg::t_coord'(7 * 65536));
        // repeats the arc
        send_at(vpcn_pkg::K_REPEAT, 1'b0, vpcn_pkg::t_coord'(3 * 65536), vpcn_pkg::C_MIN);
        send_at(vpcn_pkg::K_MOVE, 1'b1, vpcn_pkg::t_coord'(10), vpcn_pkg::t_coord'(20));
        // moveto repeat: lineto
        send_at(vpcn_pkg::K_REPEAT, 1'b0, vpcn_pkg::t_coord'(30), vpcn_pkg::t_coord'(40));
        send_at(vpcn_pkg::K_CLOSE, 1'b0, rand_coord(), rand_coord());
        send_at(vpcn_pkg::K_REPEAT, 1'b1, '0, '0);                      // repeat after close
        send_at(vpcn_pkg::K_SCUBIC, 1'b1, rand_coord(), rand_coord());  // after close

        // Implicit close fires once, never again.
        drain();
        set_mode(1'b0, 1'b1);
        send_at(vpcn_pkg::K_END, 1'b0, '0, '0);
        send_at(vpcn_pkg::K_END, 1'b1, '0, '0);

        // ---- random part: four register settings ----
        for (int ph = 0; ph < 4; ph++) begin
            drain();
            set_mode(ph == 1 || ph == 2, ph == 1 || ph == 3);
            // first setting opens with a long stretch of back-to-back transfers
            idle_pct = (ph == 0) ? 0 : 32;
            mark = n_sent;
            while (n_sent - mark < PHASE_ITEMS) begin
                if (ph == 0 && n_sent - mark > 150) idle_pct = 32;
                if ($urandom_range(49) == 0) drain();
                if ($urandom_range(4) != 0) begin
                    send_path();
                end else begin
                    send_noise();
                end
            end
        end

        drain();
        repeat (8) @(negedge clk);

        $display("Sent %0d path commands under %0d register settings", n_sent, n_settings);
        $display("(points mode and implicit close each on and off); %0d results compared",
                 checked);
        if (fails == 0 && pending == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
